>>> hdl/mhs_pkg.sv
// Shared constants, types and the signed compare for the min-heap sorter.
package mhs_pkg;

  localparam int CAPACITY = 64;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int DATA_W   = 32;

  typedef logic [DATA_W-1:0] word_t;
  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [CNT_W-1:0]  cnt_t;

  typedef struct packed {
    logic  ins;
    logic  srt;
    word_t value;
    cnt_t  count;
  } mhs_cmd_t;

  typedef enum logic [3:0] {
    H_IDLE,
    H_UP,
    H_UPC,
    H_RD0,
    H_RDK,
    H_WK,
    H_CHK,
    H_RDL,
    H_RDR,
    H_CMP
  } heap_state_t;

  typedef enum logic [2:0] {
    T_IDLE,
    T_INS,
    T_START,
    T_SORT,
    T_OUT_RD,
    T_OUT_LD,
    T_OUT_WAIT
  } top_state_t;

  function automatic logic greater_s(word_t a, word_t b);
    return $signed(a) > $signed(b);
  endfunction

endpackage

>>> hdl/mhs_heap.sv
// Heap store with the sift-up and in-place heap sort sequencer around one compare unit.
module mhs_heap (
  input  logic              clk,
  input  logic              rst_n,
  input  mhs_pkg::mhs_cmd_t cmd,
  output logic              done,
  input  mhs_pkg::addr_t    rd_addr,
  output mhs_pkg::word_t    rd_data
);
  import mhs_pkg::*;

  word_t       mem [CAPACITY];
  word_t       rd_data_r;

  heap_state_t state_r, state_nxt;
  word_t       val_r, val_nxt;
  word_t       tmp_r, tmp_nxt;
  word_t       cand_r, cand_nxt;
  addr_t       pos_r, pos_nxt;
  addr_t       k_r, k_nxt;
  addr_t       cidx_r, cidx_nxt;

  logic        we;
  addr_t       wa;
  word_t       wd;
  addr_t       ra;
  word_t       cmp_a, cmp_b;
  logic        gt;

  logic [ADDR_W:0] kid;
  logic [ADDR_W:0] kid1;
  logic [ADDR_W:0] end_w;
  addr_t           parent;

  assign kid     = {pos_r, 1'b1};
  assign kid1    = kid + {{ADDR_W{1'b0}}, 1'b1};
  assign end_w   = {1'b0, k_r} - {{ADDR_W{1'b0}}, 1'b1};
  assign parent  = (pos_r - addr_t'(1)) >> 1;
  assign gt      = greater_s(cmp_a, cmp_b);
  assign rd_data = rd_data_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_data_r <= mem[ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= H_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    val_r  <= val_nxt;
    tmp_r  <= tmp_nxt;
    cand_r <= cand_nxt;
    pos_r  <= pos_nxt;
    k_r    <= k_nxt;
    cidx_r <= cidx_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    val_nxt   = val_r;
    tmp_nxt   = tmp_r;
    cand_nxt  = cand_r;
    pos_nxt   = pos_r;
    k_nxt     = k_r;
    cidx_nxt  = cidx_r;
    we        = 1'b0;
    wa        = pos_r;
    wd        = val_r;
    ra        = rd_addr;
    cmp_a     = val_r;
    cmp_b     = cand_r;
    done      = 1'b0;
    case (state_r)
      H_IDLE: begin
        if (cmd.ins) begin
          val_nxt   = cmd.value;
          pos_nxt   = cmd.count[ADDR_W-1:0];
          state_nxt = H_UP;
        end else if (cmd.srt) begin
          if (cmd.count <= cnt_t'(1)) begin
            done = 1'b1;
          end else begin
            k_nxt     = addr_t'(cmd.count - cnt_t'(1));
            ra        = '0;
            state_nxt = H_RDK;
          end
        end
      end
      H_UP: begin
        if (pos_r == '0) begin
          we        = 1'b1;
          done      = 1'b1;
          state_nxt = H_IDLE;
        end else begin
          ra        = parent;
          state_nxt = H_UPC;
        end
      end
      H_UPC: begin
        cmp_a = rd_data_r;
        cmp_b = val_r;
        we    = 1'b1;
        if (gt) begin
          wd        = rd_data_r;
          pos_nxt   = parent;
          state_nxt = H_UP;
        end else begin
          done      = 1'b1;
          state_nxt = H_IDLE;
        end
      end
      H_RD0: begin
        ra        = '0;
        state_nxt = H_RDK;
      end
      H_RDK: begin
        tmp_nxt   = rd_data_r;
        ra        = k_r;
        state_nxt = H_WK;
      end
      H_WK: begin
        val_nxt   = rd_data_r;
        we        = 1'b1;
        wa        = k_r;
        wd        = tmp_r;
        pos_nxt   = '0;
        state_nxt = H_CHK;
      end
      H_CHK: begin
        if (kid > end_w) begin
          we = 1'b1;
          if (k_r == addr_t'(1)) begin
            done      = 1'b1;
            state_nxt = H_IDLE;
          end else begin
            k_nxt     = k_r - addr_t'(1);
            state_nxt = H_RD0;
          end
        end else begin
          ra        = kid[ADDR_W-1:0];
          state_nxt = H_RDL;
        end
      end
      H_RDL: begin
        cand_nxt = rd_data_r;
        cidx_nxt = kid[ADDR_W-1:0];
        if (kid1 <= end_w) begin
          ra        = kid1[ADDR_W-1:0];
          state_nxt = H_RDR;
        end else begin
          state_nxt = H_CMP;
        end
      end
      H_RDR: begin
        cmp_a = cand_r;
        cmp_b = rd_data_r;
        if (gt) begin
          cand_nxt = rd_data_r;
          cidx_nxt = cidx_r + addr_t'(1);
        end
        state_nxt = H_CMP;
      end
      H_CMP: begin
        cmp_a = val_r;
        cmp_b = cand_r;
        we    = 1'b1;
        if (gt) begin
          wd        = cand_r;
          pos_nxt   = cidx_r;
          state_nxt = H_CHK;
        end else if (k_r == addr_t'(1)) begin
          done      = 1'b1;
          state_nxt = H_IDLE;
        end else begin
          k_nxt     = k_r - addr_t'(1);
          state_nxt = H_RD0;
        end
      end
      default: begin
        state_nxt = H_IDLE;
      end
    endcase
  end

endmodule

>>> hdl/min_heap_sort.sv
// Top level of the min-heap sorter: stream ports, set bookkeeping and result output.
//
//  channel | dir | tdata              | tlast        | tuser
//  in_     | in  | value [31:0]       | last_value   | -
//  out_    | out | sorted_value[31:0] | last_result  | dropped
//
// An insert climbs one level at a time, each level a read through the single registered read
// port of the heap store and a compare in the shared compare unit.
// The sort makes n - 1 extractions, each a swap of the root with the last word and a sift-down.
// Each result word is then read from the store, registered and held until the output accepts it.
// Reset clears the set count, the drop flag and the sequencers; the store needs no clearing.
// No input word is taken from the last word of a set until its final result is accepted.
module min_heap_sort (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [31:0]           in_tdata,   // [31:0] value
  input  logic                  in_tlast,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [31:0]           out_tdata,  // [31:0] sorted_value
  output logic                  out_tlast,
  output logic                  out_tuser   // [0] dropped
);
  import mhs_pkg::*;

  top_state_t state_r, state_nxt;
  cnt_t       count_r, count_nxt;
  logic       over_r, over_nxt;
  logic       last_r, last_nxt;
  addr_t      j_r, j_nxt;
  logic       out_valid_r, out_valid_nxt;
  word_t      out_data_r, out_data_nxt;
  logic       out_last_r, out_last_nxt;
  logic       out_drop_r, out_drop_nxt;

  mhs_cmd_t   cmd;
  logic       done;
  addr_t      rd_addr;
  word_t      rd_data;
  logic       in_acc;

  mhs_heap u_heap (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (cmd),
    .done    (done),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign in_tready  = (state_r == T_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_drop_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= T_IDLE;
      count_r     <= '0;
      over_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      over_r      <= over_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    last_r     <= last_nxt;
    j_r        <= j_nxt;
    out_data_r <= out_data_nxt;
    out_last_r <= out_last_nxt;
    out_drop_r <= out_drop_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    over_nxt      = over_r;
    last_nxt      = last_r;
    j_nxt         = j_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    out_last_nxt  = out_last_r;
    out_drop_nxt  = out_drop_r;
    cmd.ins       = 1'b0;
    cmd.srt       = 1'b0;
    cmd.value     = in_tdata;
    cmd.count     = count_r;
    rd_addr       = j_r;
    case (state_r)
      T_IDLE: begin
        if (in_acc) begin
          last_nxt = in_tlast;
          if (count_r < cnt_t'(CAPACITY)) begin
            cmd.ins   = 1'b1;
            count_nxt = count_r + cnt_t'(1);
            state_nxt = T_INS;
          end else begin
            over_nxt = 1'b1;
            if (in_tlast) begin
              state_nxt = T_START;
            end
          end
        end
      end
      T_INS: begin
        if (done) begin
          state_nxt = last_r ? T_START : T_IDLE;
        end
      end
      T_START: begin
        cmd.srt = 1'b1;
        if (done) begin
          j_nxt     = '0;
          state_nxt = T_OUT_RD;
        end else begin
          state_nxt = T_SORT;
        end
      end
      T_SORT: begin
        if (done) begin
          j_nxt     = '0;
          state_nxt = T_OUT_RD;
        end
      end
      T_OUT_RD: begin
        state_nxt = T_OUT_LD;
      end
      T_OUT_LD: begin
        out_valid_nxt = 1'b1;
        out_data_nxt  = rd_data;
        out_last_nxt  = (cnt_t'(j_r) + cnt_t'(1) == count_r);
        out_drop_nxt  = over_r;
        state_nxt     = T_OUT_WAIT;
      end
      T_OUT_WAIT: begin
        if (out_tready) begin
          out_valid_nxt = 1'b0;
          if (out_last_r) begin
            count_nxt = '0;
            over_nxt  = 1'b0;
            state_nxt = T_IDLE;
          end else begin
            j_nxt     = j_r + addr_t'(1);
            rd_addr   = j_r + addr_t'(1);
            state_nxt = T_OUT_LD;
          end
        end
      end
      default: begin
        state_nxt = T_IDLE;
      end
    endcase
  end

endmodule
